>>> rtl/core/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  // Size of the code table and longest code that the table accepts.
  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 16;

  // Fixed widths of the code word and of an output byte.
  localparam int WORD_BITS = 16;
  localparam int BYTE_BITS = 8;

  // A loaded length is clipped to the shorter of the two limits.
  localparam int LEN_LIMIT = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Pending bits plus one full code fit in the accumulator.
  localparam int ACC_W = WORD_BITS + BYTE_BITS - 1;

  // Queue between the front and back ends.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  // One code table entry: left-aligned code and its length.
  typedef struct packed {
    logic [WORD_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } entry_t;

  // One classified operation for the back end.
  typedef struct packed {
    logic   is_flush;
    entry_t entry;
  } op_t;

endpackage

>>> rtl/core/hcbp_front.sv
// Front end: accepts items, keeps the code table and looks up codes.
module hcbp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [hcbp_pkg::SYM_W-1:0] symbol_i,
  input  logic [hcbp_pkg::WORD_BITS-1:0] code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0] code_length_i,
  input  logic [hcbp_pkg::LVL_W-1:0] fifo_level_i,
  output logic                       push_o,
  output hcbp_pkg::op_t              push_op_o
);

  hcbp_pkg::entry_t table_mem [hcbp_pkg::SYMBOL_COUNT];
  hcbp_pkg::entry_t rd_entry_q;

  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q, s1_flush_d;

  logic                            accept;
  logic                            in_range;
  logic                            do_load;
  logic                            do_read;
  logic [hcbp_pkg::ADDR_W-1:0]     addr;
  logic [hcbp_pkg::LEN_W-1:0]      len_sat;
  logic [hcbp_pkg::LEN_W-1:0]      mask_shift;
  logic [hcbp_pkg::WORD_BITS-1:0]  keep_mask;
  logic [hcbp_pkg::LVL_W:0]        occupancy;
  hcbp_pkg::entry_t                wr_entry;

  // Room is reserved for the queued items plus the one in the lookup stage.
  assign occupancy = {1'b0, fifo_level_i} + (hcbp_pkg::LVL_W + 1)'(s1_valid_q);
  assign s_ready_o = occupancy < (hcbp_pkg::LVL_W + 1)'(hcbp_pkg::FIFO_DEPTH);
  assign accept    = s_valid_i & s_ready_o;

  assign in_range = {1'b0, symbol_i} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT);
  assign addr     = symbol_i[hcbp_pkg::ADDR_W-1:0];

  // Classify the item by its mode.
  always_comb begin
    do_load    = 1'b0;
    do_read    = 1'b0;
    s1_flush_d = 1'b0;
    case (hcbp_pkg::mode_e'(mode_i))
      hcbp_pkg::MODE_LOAD: begin
        do_load = accept & in_range;
      end
      hcbp_pkg::MODE_ENCODE: begin
        do_read = accept & in_range;
      end
      hcbp_pkg::MODE_FLUSH: begin
        s1_flush_d = accept;
      end
      default: begin
        do_load = 1'b0;
      end
    endcase
    s1_valid_d = do_read | s1_flush_d;
  end

  // Clip the length and clear code bits below it before writing the table.
  assign len_sat = (code_length_i > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT))
                 ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT) : code_length_i;
  assign mask_shift    = hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS) - len_sat;
  assign keep_mask     = {hcbp_pkg::WORD_BITS{1'b1}} << mask_shift;
  assign wr_entry.code = code_word_i & keep_mask;
  assign wr_entry.len  = len_sat;

  // Code table with registered read.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      table_mem[addr] <= wr_entry;
    end
    if (do_read) begin
      rd_entry_q <= table_mem[addr];
    end
  end

  // Lookup stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
    end
  end

  assign push_o             = s1_valid_q;
  assign push_op_o.is_flush = s1_flush_q;
  assign push_op_o.entry    = rd_entry_q;

endmodule

>>> rtl/core/hcbp_fifo.sv
// Short queue of classified operations between front and back ends.
module hcbp_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  hcbp_pkg::op_t              push_op_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output hcbp_pkg::op_t              head_o,
  output logic [hcbp_pkg::LVL_W-1:0] level_o
);

  hcbp_pkg::op_t slots_q [hcbp_pkg::FIFO_DEPTH];

  logic [hcbp_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [hcbp_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [hcbp_pkg::LVL_W-1:0] count_q, count_d;

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + hcbp_pkg::PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + hcbp_pkg::PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + hcbp_pkg::LVL_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - hcbp_pkg::LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_o  = slots_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign level_o = count_q;

endmodule

>>> rtl/core/hcbp_back.sv
// Back end: appends code bits to the accumulator and emits bytes.
module hcbp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  hcbp_pkg::op_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    pad_bits_o,
  output logic          byte_valid_o,
  output logic          last_o
);

  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic       sec_valid_q, sec_valid_d;
  logic [7:0] sec_byte_q, sec_byte_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [2:0] out_pad_q, out_pad_d;
  logic       out_bv_q, out_bv_d;
  logic       out_last_q, out_last_d;

  logic                          load_en;
  logic [hcbp_pkg::LEN_W-1:0]    clen;
  logic [hcbp_pkg::LEN_W-1:0]    code_shift;
  logic [hcbp_pkg::ACC_W-1:0]    acc;
  logic [hcbp_pkg::LEN_W-1:0]    total;
  logic [hcbp_pkg::LEN_W-1:0]    sh0;
  logic [hcbp_pkg::LEN_W-1:0]    sh1;
  logic [7:0]                    byte0;
  logic [7:0]                    byte1;
  logic [1:0]                    nbytes;
  logic [6:0]                    rem_mask;
  logic [3:0]                    pad;

  // The output register takes a new result when it is empty or being drained.
  assign load_en = !out_valid_q | out_ready_i;
  assign pop_o   = load_en & !sec_valid_q & !empty_i;

  // Append the head code to the pending bits.
  assign clen       = head_i.entry.len;
  assign code_shift = hcbp_pkg::LEN_W'(hcbp_pkg::WORD_BITS) - clen;
  assign acc        = (hcbp_pkg::ACC_W'(pend_bits_q) << clen)
                    | (hcbp_pkg::ACC_W'(head_i.entry.code) >> code_shift);
  assign total      = hcbp_pkg::LEN_W'(pend_cnt_q) + clen;
  assign nbytes     = total[4:3];
  assign sh0        = total - hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_BITS);
  assign sh1        = total - hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_BITS);
  assign byte0      = 8'(acc >> sh0);
  assign byte1      = 8'(acc >> sh1);
  assign rem_mask   = (7'd1 << total[2:0]) - 7'd1;
  assign pad        = 4'(hcbp_pkg::BYTE_BITS) - {1'b0, pend_cnt_q};

  // Result selection and accumulator update.
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    sec_valid_d = sec_valid_q;
    sec_byte_d  = sec_byte_q;
    out_valid_d = out_valid_q & !out_ready_i;
    out_byte_d  = out_byte_q;
    out_pad_d   = out_pad_q;
    out_bv_d    = out_bv_q;
    out_last_d  = out_last_q;
    if (load_en && sec_valid_q) begin
      // Second byte of an encode that completed two bytes.
      sec_valid_d = 1'b0;
      out_valid_d = 1'b1;
      out_byte_d  = sec_byte_q;
      out_pad_d   = 3'd0;
      out_bv_d    = 1'b1;
      out_last_d  = 1'b1;
    end else if (pop_o) begin
      if (head_i.is_flush) begin
        // Flush the partial byte, zero-padded at the low end.
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        if (pend_cnt_q == 3'd0) begin
          out_byte_d = 8'd0;
          out_pad_d  = 3'd0;
          out_bv_d   = 1'b0;
        end else begin
          out_byte_d = 8'({1'b0, pend_bits_q} << pad);
          out_pad_d  = pad[2:0];
          out_bv_d   = 1'b1;
        end
        pend_bits_d = 7'd0;
        pend_cnt_d  = 3'd0;
      end else begin
        // Encode: zero, one or two complete bytes.
        pend_bits_d = 7'(acc) & rem_mask;
        pend_cnt_d  = total[2:0];
        if (nbytes != 2'd0) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte0;
          out_pad_d   = 3'd0;
          out_bv_d    = 1'b1;
          out_last_d  = (nbytes == 2'd1);
        end
        if (nbytes == 2'd2) begin
          sec_valid_d = 1'b1;
          sec_byte_d  = byte1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= 7'd0;
      pend_cnt_q  <= 3'd0;
      sec_valid_q <= 1'b0;
      sec_byte_q  <= 8'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_pad_q   <= 3'd0;
      out_bv_q    <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      sec_valid_q <= sec_valid_d;
      sec_byte_q  <= sec_byte_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_pad_q   <= out_pad_d;
      out_bv_q    <= out_bv_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign pad_bits_o   = out_pad_q;
  assign byte_valid_o = out_bv_q;
  assign last_o       = out_last_q;

endmodule

>>> rtl/core/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: front end, queue and back end.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: mode; tdata: symbol, code_word, code_length
//  m_axis    out        tuser: byte_valid; tdata: out_byte, pad_bits; tlast: last
//
// One item is accepted per cycle while the queue and the lookup stage together
// hold fewer than four operations; loads only write the table and give no result.
// A result leaves the block through the table lookup register, then the queue,
// then the output register; the back end issues one result per cycle while the
// output is not stalled, so an encode that completes two bytes issues them in turn.
// Reset clears the bit accumulator and the queue; the code table holds no
// reset value and must be loaded before a symbol is encoded.
// A stall on the output fills the queue and then drops s_axis_tready_o.
module huffman_code_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // symbol[7:0], code_word[23:8], code_length[28:24]
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // out_byte[7:0], pad_bits[10:8]
  output logic [0:0]  m_axis_tuser_o,  // byte_valid[0]
  output logic        m_axis_tlast_o
);

  logic                       push;
  hcbp_pkg::op_t              push_op;
  logic                       pop;
  logic                       empty;
  hcbp_pkg::op_t              head;
  logic [hcbp_pkg::LVL_W-1:0] level;
  logic [7:0]                 out_byte;
  logic [2:0]                 pad_bits;
  logic                       byte_valid;

  // Accept, classify and look up codes.
  hcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_o     (s_axis_tready_o),
    .mode_i        (s_axis_tuser_i),
    .symbol_i      (s_axis_tdata_i[7:0]),
    .code_word_i   (s_axis_tdata_i[23:8]),
    .code_length_i (s_axis_tdata_i[28:24]),
    .fifo_level_i  (level),
    .push_o        (push),
    .push_op_o     (push_op)
  );

  // Decoupling queue.
  hcbp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head),
    .level_o   (level)
  );

  // Bit packing and output register.
  hcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .pad_bits_o   (pad_bits),
    .byte_valid_o (byte_valid),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, pad_bits, out_byte};
  assign m_axis_tuser_o = byte_valid;

endmodule

>>> tb/huffman_code_bit_packer_tb.sv
// Self-checking testbench for the Huffman code bit packer: table loads, encoding and flushes.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;

  // Mode 3 has no meaning and must be dropped by the block.
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam int GAP_PERCENT  = 19;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 5_000_000;

  // One output byte transaction as the block reports it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] pad_bits;
    logic       byte_valid;
    logic       last;
  } packed_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  huffman_code_bit_packer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // symbol[7:0], code_word[23:8], code_length[28:24]
    .s_axis_tuser_i  (s_tuser),   // mode[1:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // out_byte[7:0], pad_bits[10:8]
    .m_axis_tuser_o  (m_axis_tuser_o),  // byte_valid[0]
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow copy of the code table and the bit accumulator.
  hcbp_pkg::entry_t code_table [hcbp_pkg::SYMBOL_COUNT];
  logic [6:0]       pend_bits = '0;
  logic [2:0]       pend_count = '0;
  packed_byte_t     expected_bytes_q[$];

  // Knobs shared between the test sequence and the two bus sides.
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int hold_req_cnt = 0;
  int hold_done_cnt = 0;

  // Run statistics.
  int err_count = 0;
  int results_seen = 0;
  int input_stall_cycles = 0;
  int n_loads = 0;
  int n_encodes = 0;
  int n_flushes = 0;
  int n_ignored = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the byte transactions that one accepted item causes.
  function automatic void predict_packing(logic [1:0] mode, logic [7:0] sym,
                                          logic [15:0] word, logic [4:0] len);
    logic [4:0]   eff_len;
    logic [15:0]  keep;
    logic [31:0]  acc;
    int           total;
    int           nbytes;
    packed_byte_t res;
    case (mode)
      hcbp_pkg::MODE_LOAD: begin
        eff_len = (int'(len) > hcbp_pkg::LEN_LIMIT) ? 5'(hcbp_pkg::LEN_LIMIT) : len;
        keep = (eff_len == 0) ? 16'h0000
             : 16'(16'hFFFF << (hcbp_pkg::WORD_BITS - int'(eff_len)));
        code_table[sym].code = word & keep;
        code_table[sym].len = eff_len;
      end
      hcbp_pkg::MODE_ENCODE: begin
        eff_len = code_table[sym].len;
        if (eff_len != 0) begin
          acc = ({25'b0, pend_bits} << eff_len) |
                ({16'b0, code_table[sym].code} >> (hcbp_pkg::WORD_BITS - int'(eff_len)));
          total = int'(pend_count) + int'(eff_len);
          nbytes = total / hcbp_pkg::BYTE_BITS;
          for (int k = 0; k < nbytes; k++) begin
            res.out_byte = 8'(acc >> (total - hcbp_pkg::BYTE_BITS * (k + 1)));
            res.pad_bits = 3'd0;
            res.byte_valid = 1'b1;
            res.last = (k == nbytes - 1);
            expected_bytes_q.push_back(res);
          end
          total = total % hcbp_pkg::BYTE_BITS;
          pend_count = 3'(total);
          pend_bits = 7'(acc & ((32'd1 << total) - 32'd1));
        end
      end
      hcbp_pkg::MODE_FLUSH: begin
        if (pend_count == 0) begin
          res = '{out_byte: 8'd0, pad_bits: 3'd0, byte_valid: 1'b0, last: 1'b1};
        end else begin
          res.pad_bits = 3'(hcbp_pkg::BYTE_BITS - int'(pend_count));
          res.out_byte = 8'({1'b0, pend_bits} << res.pad_bits);
          res.byte_valid = 1'b1;
          res.last = 1'b1;
        end
        expected_bytes_q.push_back(res);
        pend_bits = '0;
        pend_count = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one item and hold it until the block takes it; called just after a rising edge.
  task automatic send_item(logic [1:0] mode, logic [7:0] sym, logic [15:0] word,
                           logic [4:0] len);
    while (src_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {3'b000, len, word, sym};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_packing(mode, sym, word, len);
    case (mode)
      hcbp_pkg::MODE_LOAD:   n_loads++;
      hcbp_pkg::MODE_ENCODE: n_encodes++;
      hcbp_pkg::MODE_FLUSH:  n_flushes++;
      default:               n_ignored++;
    endcase
  endtask

  // Code lengths lean to the legal range but also hit zero and the saturating values.
  function automatic logic [4:0] random_code_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 5'd0;
    if (pick < 18) return 5'($urandom_range(31, 17));
    return 5'($urandom_range(16, 1));
  endfunction

  task automatic load_random_entry(logic [7:0] sym);
    send_item(hcbp_pkg::MODE_LOAD, sym, 16'($urandom), random_code_length());
  endtask

  // A message of encodes with the odd reload or ignored item, closed by a flush.
  task automatic send_message(int n_symbols);
    int pick;
    for (int i = 0; i < n_symbols; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_random_entry(8'($urandom));
      end else if (pick < 11) begin
        send_item(MODE_IGNORED, 8'($urandom), 16'($urandom), 5'($urandom));
      end else begin
        send_item(hcbp_pkg::MODE_ENCODE, 8'($urandom), 16'($urandom), 5'($urandom));
      end
    end
    send_item(hcbp_pkg::MODE_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  // Extremes of the table entry and every flush and byte-completion case.
  task automatic test_directed_cases();
    send_item(hcbp_pkg::MODE_LOAD, 8'd0, 16'hFFFF, 5'd16);
    send_item(hcbp_pkg::MODE_LOAD, 8'd255, 16'h8000, 5'd1);
    send_item(hcbp_pkg::MODE_LOAD, 8'd1, 16'hFFFF, 5'd0);   // zero-length code, stray bits
    send_item(hcbp_pkg::MODE_LOAD, 8'd2, 16'hAAAA, 5'd31);  // saturates to the longest code
    send_item(hcbp_pkg::MODE_LOAD, 8'd3, 16'hFFFF, 5'd3);   // stray bits below the code
    send_item(hcbp_pkg::MODE_LOAD, 8'd4, 16'h0000, 5'd16);
    send_item(hcbp_pkg::MODE_LOAD, 8'd5, 16'h5555, 5'd17);
    send_item(MODE_IGNORED, 8'd0, 16'h0000, 5'd1);
    send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 16'h0000, 5'd0);  // nothing pending
    send_item(hcbp_pkg::MODE_ENCODE, 8'd1, 16'h0000, 5'd0); // emits nothing
    send_item(hcbp_pkg::MODE_ENCODE, 8'd255, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_FLUSH, 8'd255, 16'hFFFF, 5'd31);  // seven padding bits
    send_item(hcbp_pkg::MODE_ENCODE, 8'd3, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd3, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd255, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd0, 16'h0000, 5'd0); // two bytes, seven bits left
    send_item(hcbp_pkg::MODE_ENCODE, 8'd2, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd4, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd255, 16'h0000, 5'd0);  // lands on a byte boundary
    send_item(hcbp_pkg::MODE_ENCODE, 8'd5, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd0, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_ENCODE, 8'd3, 16'h0000, 5'd0);
    send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 16'h0000, 5'd0);  // five padding bits
  endtask

  // Give every symbol an entry so that random encodes stay within the contract.
  task automatic test_table_fill();
    for (int s = 0; s < hcbp_pkg::SYMBOL_COUNT; s++) load_random_entry(8'(s));
  endtask

  task automatic test_random_messages();
    for (int m = 0; m < 16; m++) send_message($urandom_range(30, 1));
  endtask

  // The sink holds off while long codes keep coming, so the input must stall.
  task automatic test_output_backpressure();
    logic src_gaps_saved;
    src_gaps_saved = src_gaps_on;
    src_gaps_on = 1'b0;
    send_item(hcbp_pkg::MODE_LOAD, 8'd7, 16'($urandom), 5'd16);
    hold_req_cnt++;
    for (int i = 0; i < 40; i++) begin
      send_item(hcbp_pkg::MODE_ENCODE, (i % 2 == 0) ? 8'd7 : 8'($urandom),
                16'h0000, 5'd0);
    end
    send_item(hcbp_pkg::MODE_FLUSH, 8'd0, 16'h0000, 5'd0);
    src_gaps_on = src_gaps_saved;
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_steady_stream();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    for (int m = 0; m < 5; m++) send_message($urandom_range(25, 10));
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // Sink side: random stalls, a counted hold-off on request, or always ready.
  initial begin : sink_ready_drive
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_done_cnt) begin
        stall_left = HOLD_CYCLES;
        hold_done_cnt++;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on) begin
        m_tready <= ($urandom_range(99) >= GAP_PERCENT);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk_i) begin
    packed_byte_t got;
    packed_byte_t want;
    if (rst_ni) begin
      if (s_tvalid && !s_axis_tready_o) input_stall_cycles++;
      if (m_axis_tvalid_o && m_tready) begin
        got = '{out_byte: m_axis_tdata_o[7:0], pad_bits: m_axis_tdata_o[10:8],
                byte_valid: m_axis_tuser_o[0], last: m_axis_tlast_o};
        results_seen++;
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected output: byte=%02h pad=%0d valid=%0b last=%0b",
                   $time, got.out_byte, got.pad_bits, got.byte_valid, got.last);
          err_count++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (got != want) begin
            $display({"%0t: mismatch: expected byte=%02h pad=%0d valid=%0b last=%0b,",
                      " got byte=%02h pad=%0d valid=%0b last=%0b"},
                     $time, want.out_byte, want.pad_bits, want.byte_valid, want.last,
                     got.out_byte, got.pad_bits, got.byte_valid, got.last);
            err_count++;
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_table_fill();
    test_random_messages();
    test_output_backpressure();
    test_steady_stream();
    test_random_messages();
    s_tvalid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d ignored items.",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("Checked %0d output transactions; input held off for %0d cycles.",
             results_seen, input_stall_cycles);
    if (err_count == 0) begin
      $display("huffman_code_bit_packer_tb: clean");
    end else begin
      $display("huffman_code_bit_packer_tb: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d output transactions still expected.",
             expected_bytes_q.size());
    $display("huffman_code_bit_packer_tb: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_front.sv
rtl/core/hcbp_fifo.sv
rtl/core/hcbp_back.sv
rtl/core/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_tb.sv
